// ----- rtl/core/gcbf_pkg.sv -----
`timescale 1ns / 1ps
package gcbf_pkg;

	// window position width; positions saturate at all ones
	localparam int LEN_W      = 20;
	localparam int CHUNK_W    = 20;
	localparam int SIZE_W     = 20;
	localparam int GEAR_W     = 64;
	localparam int CMP_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

	// queue between front and back
	localparam int MQ_DEPTH = 4;
	localparam int MQ_AW    = 2;
	// result queue
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW    = 1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic [1:0] KIND_MAIN   = 2'd0;
	localparam logic [1:0] KIND_BACKUP = 2'd1;
	localparam logic [1:0] KIND_LIMIT  = 2'd2;
	localparam logic [1:0] KIND_SHORT  = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SIZE    = 3'd0,
		REG_MAX_SIZE    = 3'd1,
		REG_CUT_MASK    = 3'd2,
		REG_BACKUP_MASK = 3'd3,
		REG_TTTD_MODE   = 3'd4,
		REG_SKIP_MIN    = 3'd5
	} reg_idx_t;

	localparam logic [SIZE_W-1:0] MIN_SIZE_RST    = 20'd2048;
	localparam logic [SIZE_W-1:0] MAX_SIZE_RST    = 20'd65536;
	localparam logic [GEAR_W-1:0] CUT_MASK_RST    = 64'd8191;
	localparam logic [GEAR_W-1:0] BACKUP_MASK_RST = 64'd4095;

	typedef struct packed {
		logic              command;
		logic [7:0]        table_index;
		logic [GEAR_W-1:0] table_value;
		logic [7:0]        data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_length;
		logic [1:0]         cut_kind;
	} result_t;

	typedef struct packed {
		logic [SIZE_W-1:0] min_size;
		logic [SIZE_W-1:0] max_size;
		logic [GEAR_W-1:0] cut_mask;
		logic [GEAR_W-1:0] backup_mask;
		logic              tttd_mode;
		logic              skip_min;
	} cfg_t;

	// one looked-up data byte on its way to the hash unit
	typedef struct packed {
		logic              last;
		logic [GEAR_W-1:0] gear;
	} link_word_t;

endpackage

// ----- rtl/core/gcbf_front.sv -----
`timescale 1ns / 1ps
module gcbf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  gcbf_pkg::in_item_t    item,
	input  logic [gcbf_pkg::MQ_AW:0] link_level,
	output logic                  link_valid,
	output gcbf_pkg::link_word_t  link_word
);
	import gcbf_pkg::*;

	logic [GEAR_W-1:0] gear_mem [256];
	logic [GEAR_W-1:0] gear_s1;
	logic              last_s1;
	logic              valid_s1;
	logic              accept;
	logic [MQ_AW+1:0]  committed;

	// a word in the lookup stage always has a queue slot reserved
	assign committed = {1'b0, link_level} + {{(MQ_AW+1){1'b0}}, valid_s1};
	assign full      = committed >= (MQ_AW+2)'(MQ_DEPTH);
	assign accept    = push && !full;

	always_ff @(posedge clk) begin
		if (accept && item.command == CMD_LOAD) begin
			gear_mem[item.table_index] <= item.table_value;
		end
		if (accept && item.command == CMD_DATA) begin
			gear_s1 <= gear_mem[item.data_byte];
			last_s1 <= item.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && item.command == CMD_DATA;
		end
	end

	assign link_valid     = valid_s1;
	assign link_word.last = last_s1;
	assign link_word.gear = gear_s1;

endmodule

// ----- rtl/core/gcbf_link_fifo.sv -----
`timescale 1ns / 1ps
module gcbf_link_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_valid,
	input  gcbf_pkg::link_word_t     wr_word,
	output logic [gcbf_pkg::MQ_AW:0] level,
	output logic                     rd_valid,
	output gcbf_pkg::link_word_t     rd_word,
	input  logic                     rd_take
);
	import gcbf_pkg::*;

	link_word_t           slot_q [MQ_DEPTH];
	logic [MQ_AW-1:0]     wr_ptr_q;
	logic [MQ_AW-1:0]     rd_ptr_q;
	logic [MQ_AW:0]       level_q;
	logic                 do_rd;

	assign rd_valid = level_q != '0;
	assign rd_word  = slot_q[rd_ptr_q];
	assign level    = level_q;
	assign do_rd    = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr_valid) begin
			slot_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_valid && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !wr_valid) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/gcbf_back.sv -----
`timescale 1ns / 1ps
module gcbf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gcbf_pkg::cfg_t       cfg,
	input  logic                 link_valid,
	input  gcbf_pkg::link_word_t link_word,
	output logic                 link_take,
	output logic                 empty,
	input  logic                 pop,
	output gcbf_pkg::result_t    result
);
	import gcbf_pkg::*;

	// window state
	logic [GEAR_W-1:0] fp_q;
	logic [LEN_W-1:0]  pos_q;
	logic [LEN_W-1:0]  fcut_q;
	logic [LEN_W-1:0]  bcut_q;
	logic              found_q;

	// result queue
	result_t           oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  oq_wr_q;
	logic [OQ_AW-1:0]  oq_rd_q;
	logic [OQ_AW:0]    oq_level_q;

	logic [LEN_W-1:0]  start;
	logic              hash_en;
	logic [GEAR_W-1:0] fp_new;
	logic              main_hit;
	logic              bk_hit;
	logic              main_cut;
	logic              bk_cut;
	logic [LEN_W-1:0]  pos_nx;
	logic              found_nx;
	logic [LEN_W-1:0]  fcut_nx;
	logic [LEN_W-1:0]  bcut_nx;
	logic [LEN_W-1:0]  len;
	logic [1:0]        kind;
	logic              emit;
	logic              do_pop;
	result_t           res_nx;

	always_comb begin
		start    = cfg.skip_min ? LEN_W'(cfg.min_size) : '0;
		hash_en  = !found_q
			&& CMP_W'(pos_q) >= CMP_W'(start)
			&& CMP_W'(pos_q) < CMP_W'(cfg.max_size)
			&& pos_q != POS_MAX;
		fp_new   = {fp_q[GEAR_W-2:0], 1'b0} + link_word.gear;
		main_hit = ~|(fp_new & cfg.cut_mask);
		bk_hit   = ~|(fp_new & cfg.backup_mask);
		// in two-threshold mode a main hit counts only inside a backup hit
		main_cut = hash_en && (cfg.tttd_mode ? (bk_hit && main_hit) : main_hit);
		bk_cut   = hash_en && cfg.tttd_mode && bk_hit && !main_hit;
		pos_nx   = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		found_nx = found_q || main_cut;
		fcut_nx  = main_cut ? pos_nx : fcut_q;
		bcut_nx  = bk_cut ? pos_nx : bcut_q;

		priority if (CMP_W'(pos_nx) <= CMP_W'(cfg.min_size)) begin
			len  = pos_nx;
			kind = KIND_SHORT;
		end else if (found_nx) begin
			len  = fcut_nx;
			kind = KIND_MAIN;
		end else if (cfg.tttd_mode && bcut_nx != '0) begin
			len  = bcut_nx;
			kind = KIND_BACKUP;
		end else begin
			len  = (CMP_W'(pos_nx) < CMP_W'(cfg.max_size)) ? pos_nx : LEN_W'(cfg.max_size);
			kind = KIND_LIMIT;
		end
		res_nx.chunk_length = CHUNK_W'(len);
		res_nx.cut_kind     = kind;

		// hold a last word until the result queue has room
		link_take = link_valid && (!link_word.last || oq_level_q != (OQ_AW+1)'(OQ_DEPTH));
		emit      = link_take && link_word.last;
		do_pop    = pop && oq_level_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			pos_q   <= '0;
			fcut_q  <= '0;
			bcut_q  <= '0;
			found_q <= 1'b0;
		end else if (link_take) begin
			if (link_word.last) begin
				fp_q    <= '0;
				pos_q   <= '0;
				fcut_q  <= '0;
				bcut_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (hash_en) begin
					fp_q <= fp_new;
				end
				pos_q   <= pos_nx;
				fcut_q  <= fcut_nx;
				bcut_q  <= bcut_nx;
				found_q <= found_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oq_q[oq_wr_q] <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q    <= '0;
			oq_rd_q    <= '0;
			oq_level_q <= '0;
		end else begin
			if (emit) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (do_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (emit && !do_pop) begin
				oq_level_q <= oq_level_q + 1'b1;
			end else if (do_pop && !emit) begin
				oq_level_q <= oq_level_q - 1'b1;
			end
		end
	end

	assign empty  = oq_level_q == '0;
	assign result = oq_q[oq_rd_q];

endmodule

// ----- rtl/core/gear_chunk_boundary_finder.sv -----
`timescale 1ns / 1ps
// Gear-hash chunk boundary finder. Push load words (command 0) to fill the
// 256-entry gear table, then push the bytes of a window (command 1), the last
// one flagged; one result word per window gives the chunk length and the kind
// of cut. One item is taken per clock for as long as the result side keeps
// up: the table lookup, a four-word queue and the shift-add hash unit each
// handle one byte a cycle, and a window's result is written to the result
// queue once its last byte has passed the lookup register and the queue.
// Full rises only when the internal queue backs up behind an unread result
// queue (two words). Write configuration only while idle.
module gear_chunk_boundary_finder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  gcbf_pkg::in_item_t                 item,
	output logic                               empty,
	input  logic                               pop,
	output gcbf_pkg::result_t                  result,
	input  logic                               cfg_write,
	input  logic [gcbf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gcbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gcbf_pkg::*;

	cfg_t             cfg_q;
	logic             link_valid;
	link_word_t       link_word;
	logic [MQ_AW:0]   link_level;
	logic             head_valid;
	link_word_t       head_word;
	logic             head_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_size    <= MIN_SIZE_RST;
			cfg_q.max_size    <= MAX_SIZE_RST;
			cfg_q.cut_mask    <= CUT_MASK_RST;
			cfg_q.backup_mask <= BACKUP_MASK_RST;
			cfg_q.tttd_mode   <= 1'b0;
			cfg_q.skip_min    <= 1'b1;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_SIZE:    cfg_q.min_size    <= cfg_data[SIZE_W-1:0];
				REG_MAX_SIZE:    cfg_q.max_size    <= cfg_data[SIZE_W-1:0];
				REG_CUT_MASK:    cfg_q.cut_mask    <= cfg_data[GEAR_W-1:0];
				REG_BACKUP_MASK: cfg_q.backup_mask <= cfg_data[GEAR_W-1:0];
				REG_TTTD_MODE:   cfg_q.tttd_mode   <= cfg_data[0];
				REG_SKIP_MIN:    cfg_q.skip_min    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	gcbf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.link_level (link_level),
		.link_valid (link_valid),
		.link_word  (link_word)
	);

	gcbf_link_fifo u_link (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (link_valid),
		.wr_word  (link_word),
		.level    (link_level),
		.rd_valid (head_valid),
		.rd_word  (head_word),
		.rd_take  (head_take)
	);

	gcbf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.link_valid (head_valid),
		.link_word  (head_word),
		.link_take  (head_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ----- rtl/core/gcbf_checker.sv -----
`timescale 1ns / 1ps
module gcbf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              empty,
	input logic              pop,
	input gcbf_pkg::result_t result
);
	import gcbf_pkg::*;

	// a waiting word holds until popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result word changed or vanished while not popped");

	// a mask or backup cut always lies past the first byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.cut_kind == KIND_MAIN || result.cut_kind == KIND_BACKUP))
		|-> result.chunk_length != '0)
		else $error("hash cut reported with zero length");

	// nothing is waiting while reset is held
	assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result queue not empty during reset");

endmodule

bind gear_chunk_boundary_finder gcbf_checker u_gcbf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

// ----- tb/tb_gear_chunk_boundary_finder.sv -----
`timescale 1ns / 1ps
module tb_gear_chunk_boundary_finder;
	import gcbf_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	localparam int unsigned RANDOM_WORDS = 1500;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned PRINT_CAP    = 100;

	// indexes past the last register; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b1;
	logic                  push      = 1'b0;
	logic                  full;
	in_item_t              item      = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	result_t               result;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_SIZE;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	gear_chunk_boundary_finder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// chunker mirror
	cfg_t              cfg_now;
	logic [GEAR_W-1:0] gear_copy [256];
	logic [GEAR_W-1:0] win_fp;
	logic [LEN_W-1:0]  win_pos;
	logic [LEN_W-1:0]  win_backup;
	logic [LEN_W-1:0]  win_found;
	logic              win_hit;
	result_t           chunk_q [$];

	int unsigned err_count    = 0;
	int unsigned cycle_count  = 0;
	int unsigned words_pushed = 0;
	bit          sender_idles   = 1'b1;
	bit          receiver_idles = 1'b1;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (err_count < PRINT_CAP)
			$display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
				cycle_count);
		err_count++;
	endtask

	function automatic cfg_t make_cfg(logic [SIZE_W-1:0] min_sz, logic [SIZE_W-1:0] max_sz,
		logic [GEAR_W-1:0] cut, logic [GEAR_W-1:0] backup, logic tttd, logic skip);
		cfg_t c;
		c.min_size    = min_sz;
		c.max_size    = max_sz;
		c.cut_mask    = cut;
		c.backup_mask = backup;
		c.tttd_mode   = tttd;
		c.skip_min    = skip;
		return c;
	endfunction

	function automatic in_item_t data_word(logic [7:0] b, logic last);
		in_item_t w;
		w.command     = CMD_DATA;
		w.table_index = 8'($urandom);
		w.table_value = {$urandom, $urandom};
		w.data_byte   = b;
		w.last_byte   = last;
		return w;
	endfunction

	function automatic in_item_t load_word(logic [7:0] idx, logic [GEAR_W-1:0] val);
		in_item_t w;
		w.command     = CMD_LOAD;
		w.table_index = idx;
		w.table_value = val;
		w.data_byte   = 8'($urandom);
		w.last_byte   = 1'($urandom);
		return w;
	endfunction

	task automatic clear_window();
		win_fp     = '0;
		win_pos    = '0;
		win_backup = '0;
		win_found  = '0;
		win_hit    = 1'b0;
	endtask

	// advance the mirror by one accepted word; queue the chunk a last byte closes
	task automatic chunk_step(in_item_t w);
		logic [LEN_W-1:0] start;
		logic [LEN_W-1:0] n;
		result_t          r;
		if (w.command == CMD_LOAD) begin
			gear_copy[w.table_index] = w.table_value;
			return;
		end
		start = cfg_now.skip_min ? cfg_now.min_size : '0;
		if (!win_hit && win_pos >= start && win_pos < cfg_now.max_size && win_pos != POS_MAX) begin
			win_fp = (win_fp << 1) + gear_copy[w.data_byte];
			if (cfg_now.tttd_mode) begin
				// a main hit only counts inside a backup hit
				if ((win_fp & cfg_now.backup_mask) == '0) begin
					if ((win_fp & cfg_now.cut_mask) == '0) begin
						win_hit   = 1'b1;
						win_found = win_pos + 1'b1;
					end else begin
						win_backup = win_pos + 1'b1;
					end
				end
			end else if ((win_fp & cfg_now.cut_mask) == '0) begin
				win_hit   = 1'b1;
				win_found = win_pos + 1'b1;
			end
		end
		if (win_pos != POS_MAX)
			win_pos = win_pos + 1'b1;
		if (!w.last_byte)
			return;
		n = win_pos;
		if (n <= cfg_now.min_size) begin
			r.chunk_length = n;
			r.cut_kind     = KIND_SHORT;
		end else if (win_hit) begin
			r.chunk_length = win_found;
			r.cut_kind     = KIND_MAIN;
		end else if (cfg_now.tttd_mode && win_backup != '0) begin
			r.chunk_length = win_backup;
			r.cut_kind     = KIND_BACKUP;
		end else begin
			r.chunk_length = (n < cfg_now.max_size) ? n : cfg_now.max_size;
			r.cut_kind     = KIND_LIMIT;
		end
		chunk_q.push_back(r);
		clear_window();
	endtask

	task automatic send_word(in_item_t w);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full !== 1'b0);
		words_pushed++;
		chunk_step(w);
	endtask

	task automatic send_window(int unsigned len, bit mix_loads);
		for (int unsigned i = 0; i < len; i++) begin
			if (mix_loads && $urandom_range(0, 9) == 0)
				send_word(load_word(8'($urandom), {$urandom, $urandom}));
			send_word(data_word(8'($urandom), i == len - 1));
		end
	endtask

	// hold off until every chunk is back and the pipeline has drained
	task automatic wait_idle();
		push <= 1'b0;
		while (chunk_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic apply_config(cfg_t c);
		logic [CFG_DATA_W-1:0] junk;
		wait_idle();
		junk = {$urandom, $urandom};
		// junk above each field must be dropped
		write_reg(REG_MIN_SIZE, {junk[CFG_DATA_W-1:SIZE_W], c.min_size});
		write_reg(REG_MAX_SIZE, {~junk[CFG_DATA_W-1:SIZE_W], c.max_size});
		write_reg(REG_CUT_MASK, c.cut_mask);
		write_reg(REG_BACKUP_MASK, c.backup_mask);
		write_reg(REG_TTTD_MODE, {junk[CFG_DATA_W-1:1], c.tttd_mode});
		write_reg(REG_SKIP_MIN, {~junk[CFG_DATA_W-2:0], c.skip_min});
		write_reg(REG_SPARE_LO, junk);
		write_reg(REG_SPARE_HI, ~junk);
		cfg_write <= 1'b0;
		cfg_now = c;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t        c;
		int unsigned top;
		int unsigned k;
		case ($urandom_range(0, 7))
			0: c.min_size = '0;
			1: c.min_size = POS_MAX;
			default: c.min_size = SIZE_W'($urandom_range(0, 12));
		endcase
		case ($urandom_range(0, 7))
			0: c.max_size = POS_MAX;
			1: c.max_size = (c.min_size == '0) ? 20'd1 :
				SIZE_W'($urandom_range(1, c.min_size));
			default: begin
				top = c.min_size + $urandom_range(1, 30);
				c.max_size = (top > POS_MAX) ? POS_MAX : SIZE_W'(top);
			end
		endcase
		k = $urandom_range(0, 8);
		case ($urandom_range(0, 5))
			0: c.cut_mask = '1;
			1: c.cut_mask = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
			default: c.cut_mask = (64'd1 << k) - 64'd1;
		endcase
		case ($urandom_range(0, 4))
			0: c.backup_mask = {$urandom, $urandom};
			1: c.backup_mask = '0;
			default: c.backup_mask = c.cut_mask >> $urandom_range(1, 3);
		endcase
		c.tttd_mode = 1'($urandom_range(0, 1));
		c.skip_min  = 1'($urandom_range(0, 1));
		return c;
	endfunction

	initial begin : drain_results
		int unsigned stall;
		result_t     want;
		@(posedge arst_n);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 3) : 0;
			if (stall != 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (chunk_q.size() == 0) begin
				report_mismatch("word with no chunk outstanding",
					64'(result.chunk_length), '0);
			end else begin
				want = chunk_q.pop_front();
				if (result.chunk_length !== want.chunk_length)
					report_mismatch("chunk_length", 64'(result.chunk_length),
						64'(want.chunk_length));
				if (result.cut_kind !== want.cut_kind)
					report_mismatch("cut_kind", 64'(result.cut_kind), 64'(want.cut_kind));
			end
		end
	end

	// every entry is written before any byte can read it
	task automatic load_gear_table();
		for (int i = 0; i < 256; i++) begin
			if (i == 0)
				send_word(load_word(8'(i), '1));
			else if (i == 255)
				send_word(load_word(8'(i), '0));
			else
				send_word(load_word(8'(i), {$urandom, $urandom}));
		end
	endtask

	task automatic test_reset_defaults();
		send_window(1, 1'b0);
	endtask

	task automatic test_plain_cuts();
		apply_config(make_cfg(20'd1, 20'd4, '0, '0, 1'b0, 1'b1));
		send_word(data_word(8'h00, 1'b0));
		send_word(data_word(8'hFF, 1'b0));
		send_word(data_word(8'h80, 1'b1));
		apply_config(make_cfg(20'd1, 20'd4, '1, '0, 1'b0, 1'b1));
		send_window(3, 1'b0);
	endtask

	task automatic test_backup_cuts();
		apply_config(make_cfg(20'd0, 20'd4, '1, '0, 1'b1, 1'b0));
		send_window(3, 1'b0);
		// main mask hits everywhere but the backup mask only on an all-zero fingerprint
		apply_config(make_cfg(20'd0, 20'd4, '0, '1, 1'b1, 1'b0));
		send_window(2, 1'b0);
	endtask

	task automatic test_size_corners();
		apply_config(make_cfg(20'd2, 20'd1, '0, '0, 1'b0, 1'b1));
		send_window(3, 1'b0);
		apply_config(make_cfg(POS_MAX, POS_MAX, '0, '0, 1'b1, 1'b1));
		send_window(2, 1'b0);
	endtask

	task automatic test_random_traffic();
		int unsigned base;
		int unsigned len;
		int unsigned span;
		cfg_t        c;
		base = words_pushed;
		while (words_pushed - base < RANDOM_WORDS) begin
			c = random_cfg();
			sender_idles   = ($urandom_range(0, 3) != 0);
			receiver_idles = ($urandom_range(0, 3) != 0);
			apply_config(c);
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 16))
					send_word(load_word(8'($urandom), {$urandom, $urandom}));
			span = (c.max_size > c.min_size) ? c.max_size : c.min_size;
			repeat ($urandom_range(3, 8)) begin
				case ($urandom_range(0, 5))
					0: len = c.min_size;
					1: len = c.min_size + 1;
					2: len = c.max_size;
					3: len = c.max_size + 1;
					default: len = $urandom_range(1, (span > 40) ? 40 : span + 3);
				endcase
				if (len == 0 || len > 64)
					len = $urandom_range(1, 64);
				send_window(len, 1'b1);
			end
		end
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_now = make_cfg(MIN_SIZE_RST, MAX_SIZE_RST, CUT_MASK_RST, BACKUP_MASK_RST, 1'b0, 1'b1);
		clear_window();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_gear_table();
		test_reset_defaults();
		test_plain_cuts();
		test_backup_cuts();
		test_size_corners();
		test_random_traffic();
		wait_idle();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/gcbf_pkg.sv
rtl/core/gcbf_front.sv
rtl/core/gcbf_link_fifo.sv
rtl/core/gcbf_back.sv
rtl/core/gear_chunk_boundary_finder.sv
rtl/core/gcbf_checker.sv
tb/tb_gear_chunk_boundary_finder.sv
